FILE: hw/rtl/vgt_pkg.sv
package vgt_pkg;

    localparam int ChanW  = 8;
    localparam int ColorW = 3 * ChanW;
    localparam int SegW   = 6;
    localparam int CfgIdxW = 2;

    localparam logic [CfgIdxW-1:0] REG_KEY_A = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_KEY_B = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_KEY_C = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_MODE  = 2'd3;

    localparam logic CMD_ADVANCE = 1'b0;
    localparam logic CMD_SHADE   = 1'b1;

    localparam logic MODE_MAX      = 1'b0;
    localparam logic MODE_MODULATE = 1'b1;

    localparam logic [1:0] SEG_AB = 2'd0;
    localparam logic [1:0] SEG_BC = 2'd1;
    localparam logic [1:0] SEG_CB = 2'd2;
    localparam logic [1:0] SEG_BA = 2'd3;

    typedef struct packed {
        logic               command;
        logic [7:0]         phase_step;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [7:0]         in_red;
        logic [7:0]         in_green;
        logic [7:0]         in_blue;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic look;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // (from*(64-i) + to*i) >> 6
    function automatic logic [ChanW-1:0] interp(
        input logic [ChanW-1:0] from_c,
        input logic [ChanW-1:0] to_c,
        input logic [SegW-1:0]  pos
    );
        logic [SegW:0]         w_to;
        logic [SegW:0]         w_from;
        logic [ChanW+SegW-1:0] acc;
        w_to   = {1'b0, pos};
        w_from = (SegW+1)'(1 << SegW) - w_to;
        acc    = (ChanW+SegW)'(from_c) * (ChanW+SegW)'(w_from)
               + (ChanW+SegW)'(to_c) * (ChanW+SegW)'(w_to);
        return acc[ChanW+SegW-1:SegW];
    endfunction

    function automatic logic [ChanW-1:0] blend(
        input logic             mode,
        input logic [ChanW-1:0] src,
        input logic [ChanW-1:0] grad
    );
        logic [2*ChanW-1:0] prod;
        prod = src * grad;
        if (mode == MODE_MODULATE)
            return prod[2*ChanW-1:ChanW];
        return (grad < src) ? src : grad;
    endfunction

endpackage

FILE: hw/rtl/vgt_ctrl.sv
module vgt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_command,
    input  vgt_pkg::dp_status_t   status,
    output logic                  in_stall,
    output vgt_pkg::ctl_cmd_t     cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOOK  = 2'd1;
    localparam logic [1:0] ST_BLEND = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = in_valid;
                if (in_valid && in_command == vgt_pkg::CMD_SHADE)
                    state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                cmd.look   = 1'b1;
                state_next = ST_BLEND;
            end
            ST_BLEND:
            begin
                // hold until the output slot frees
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: hw/rtl/vgt_datapath.sv
module vgt_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [vgt_pkg::CfgIdxW-1:0]           cfg_index,
    input  logic [vgt_pkg::ColorW-1:0]            cfg_data,
    input  vgt_pkg::in_item_t                     in_item,
    input  vgt_pkg::ctl_cmd_t                     cmd,
    output vgt_pkg::dp_status_t                   status,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output vgt_pkg::out_item_t                    out_item
);

    localparam int CW = vgt_pkg::ChanW;

    logic [vgt_pkg::ColorW-1:0] key_a_reg;
    logic [vgt_pkg::ColorW-1:0] key_b_reg;
    logic [vgt_pkg::ColorW-1:0] key_c_reg;
    logic                       mode_reg;
    logic [7:0]                 phase_reg;
    vgt_pkg::in_item_t          item_reg;
    logic [vgt_pkg::ColorW-1:0] grad_reg;
    logic [vgt_pkg::ColorW-1:0] grad_next;
    vgt_pkg::out_item_t         out_reg;
    logic                       out_valid_reg;

    logic [7:0]                 ring_idx;
    logic [vgt_pkg::ColorW-1:0] seg_from;
    logic [vgt_pkg::ColorW-1:0] seg_to;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_a_reg <= '0;
            key_b_reg <= '0;
            key_c_reg <= '0;
            mode_reg  <= vgt_pkg::MODE_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vgt_pkg::REG_KEY_A: key_a_reg <= cfg_data;
                vgt_pkg::REG_KEY_B: key_b_reg <= cfg_data;
                vgt_pkg::REG_KEY_C: key_c_reg <= cfg_data;
                vgt_pkg::REG_MODE:  mode_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= '0;
        else if (cmd.accept && in_item.command == vgt_pkg::CMD_ADVANCE)
            phase_reg <= phase_reg + in_item.phase_step;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            item_reg <= in_item;
        if (cmd.look)
            grad_reg <= grad_next;
    end

    assign ring_idx = item_reg.pos_x[7:0] + item_reg.pos_y[7:0]
                    + item_reg.pos_z[7:0] + phase_reg;

    always_comb
    begin
        unique case (ring_idx[7:6])
            vgt_pkg::SEG_AB: begin seg_from = key_a_reg; seg_to = key_b_reg; end
            vgt_pkg::SEG_BC: begin seg_from = key_b_reg; seg_to = key_c_reg; end
            vgt_pkg::SEG_CB: begin seg_from = key_c_reg; seg_to = key_b_reg; end
            vgt_pkg::SEG_BA: begin seg_from = key_b_reg; seg_to = key_a_reg; end
            default:         begin seg_from = key_a_reg; seg_to = key_b_reg; end
        endcase
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            grad_next[c*CW +: CW] = vgt_pkg::interp(seg_from[c*CW +: CW],
                                                    seg_to[c*CW +: CW],
                                                    ring_idx[vgt_pkg::SegW-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.out_red   <= vgt_pkg::blend(mode_reg, item_reg.in_red,
                                                grad_reg[3*CW-1:2*CW]);
            out_reg.out_green <= vgt_pkg::blend(mode_reg, item_reg.in_green,
                                                grad_reg[2*CW-1:CW]);
            out_reg.out_blue  <= vgt_pkg::blend(mode_reg, item_reg.in_blue,
                                                grad_reg[CW-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign status.out_free = !out_valid_reg || !out_stall;
    assign out_valid       = out_valid_reg;
    assign out_item        = out_reg;

endmodule

FILE: hw/rtl/vertex_gradient_tint_core.sv
// A shade item is captured, goes through the ring lookup and is then blended
// into the output register once the output is free; no new item is taken
// in until it is through. An advance item steps the phase, gives no result.
// The output register holds a result while the next item is taken in.
// Reset (rst_n low, asynchronous) clears the phase, the key colours, the mode
// and the output valid flag.
module vertex_gradient_tint_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [vgt_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [vgt_pkg::ColorW-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  vgt_pkg::in_item_t             in_item,
    output logic                          out_valid,
    input  logic                          out_stall,
    output vgt_pkg::out_item_t            out_item
);

    vgt_pkg::ctl_cmd_t   cmd;
    vgt_pkg::dp_status_t status;

    vgt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_command (in_item.command),
        .status     (status),
        .in_stall   (in_stall),
        .cmd        (cmd)
    );

    vgt_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    a_shade_looks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_item.command == vgt_pkg::CMD_SHADE) |=> cmd.look)
        else $error("shade item did not enter lookup");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid)
        else $error("emitted item not on output");

    a_no_emit_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid || !out_stall))
        else $error("result overwritten while output stalled");

    a_look_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.look |-> (in_stall && !cmd.accept))
        else $error("input taken during lookup");

endmodule
